### hdl/tsj_pkg.sv
// ----------------------------------------------------------------------------
// tsj_pkg: shared types and constants of the track slope Jacobian unit
// Holds the request and result beat layouts and the divider lane control word.
// ----------------------------------------------------------------------------
package tsj_pkg;

    // Direction codes carried in req_type.
    localparam logic REQ_LAYER_TO_SECTOR = 1'b0;
    localparam logic REQ_SECTOR_TO_LAYER = 1'b1;

    // Field widths fixed by the beat layouts.
    localparam int SLOPE_W = 20;
    localparam int COMP_W  = 16;
    localparam int DERIV_W = 32;

    // Quotient bits resolved by a divider lane, weights 2^32 down to 2^0.
    localparam int QUO_BITS = 33;

    typedef struct packed {
        logic                       req_type;
        logic signed [SLOPE_W-1:0]  slope_a;
        logic signed [SLOPE_W-1:0]  slope_b;
        logic signed [COMP_W-1:0]   axis_u_x;
        logic signed [COMP_W-1:0]   axis_u_y;
        logic signed [COMP_W-1:0]   axis_u_z;
        logic signed [COMP_W-1:0]   axis_v_x;
        logic signed [COMP_W-1:0]   axis_v_y;
        logic signed [COMP_W-1:0]   axis_v_z;
        logic signed [COMP_W-1:0]   normal_x;
        logic signed [COMP_W-1:0]   normal_y;
        logic signed [COMP_W-1:0]   normal_z;
    } tsj_req_t;

    typedef struct packed {
        logic signed [DERIV_W-1:0]  deriv_aa;
        logic signed [DERIV_W-1:0]  deriv_ab;
        logic signed [DERIV_W-1:0]  deriv_ba;
        logic signed [DERIV_W-1:0]  deriv_bb;
        logic                       denom_zero;
        logic                       saturated;
    } tsj_res_t;

    // Control word that travels with each beat through a divider lane.
    typedef struct packed {
        logic valid;
        logic neg;
        logic dz;
    } tsj_ctl_t;

endpackage

### hdl/tsj_div_lane.sv
// ----------------------------------------------------------------------------
// tsj_div_lane: pipelined restoring divider for one derivative
// Computes round(mag * 2^(2F) / den) with sign, saturation and zero kill,
// resolving one quotient bit per register stage.
// ----------------------------------------------------------------------------
module tsj_div_lane #(
    parameter int MAG_W = 54,
    parameter int DEN_W = 76,
    parameter int FRAC  = 14
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tsj_pkg::tsj_ctl_t                 ctl_in,
    input  logic [MAG_W-1:0]                  mag_in,
    input  logic [DEN_W-1:0]                  den_in,
    output tsj_pkg::tsj_ctl_t                 ctl_out,
    output logic signed [tsj_pkg::DERIV_W-1:0] quo_out,
    output logic                              sat_out
);
    import tsj_pkg::*;

    localparam int NUM_W = MAG_W + 2 * FRAC;
    localparam int TOP_W = DEN_W + QUO_BITS;
    localparam int XW    = ((NUM_W > TOP_W) ? NUM_W : TOP_W) + 2;
    localparam int QB    = QUO_BITS;

    logic [XW-1:0]    rem_reg [0:QB];
    logic [QB-1:0]    quo_reg [0:QB];
    logic [DEN_W-1:0] den_reg [0:QB];
    logic             ovf_reg [0:QB];
    tsj_ctl_t         ctl_reg [0:QB];

    logic [XW-1:0]    num_next;
    logic [XW-1:0]    top_next;

    // Entry stage: scale the numerator and flag quotients of 2^33 or more.
    assign num_next = XW'(mag_in) << (2 * FRAC);
    assign top_next = XW'(den_in) << QB;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg[0] <= '0;
        end
        else
        begin
            ctl_reg[0] <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= num_next;
        quo_reg[0] <= '0;
        den_reg[0] <= den_in;
        ovf_reg[0] <= (num_next >= top_next);
    end

    // One quotient bit per stage, most significant first.
    for (genvar j = 1; j <= QB; j++)
    begin : g_step
        logic [XW-1:0] trial;
        logic          take;

        assign trial = XW'(den_reg[j-1]) << (QB - j);
        assign take  = !ovf_reg[j-1] && (rem_reg[j-1] >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[j] <= '0;
            end
            else
            begin
                ctl_reg[j] <= ctl_reg[j-1];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[j] <= take ? (rem_reg[j-1] - trial) : rem_reg[j-1];
            quo_reg[j] <= quo_reg[j-1] | (take ? (QB'(1) << (QB - j)) : '0);
            den_reg[j] <= den_reg[j-1];
            ovf_reg[j] <= ovf_reg[j-1];
        end
    end

    // Final stage: round half away from zero, clip, apply sign, or force zero when the denominator is zero.
    logic              rnd;
    logic [QB:0]       quo_rnd;
    logic [DERIV_W:0]  limit;
    logic              clip;
    logic [DERIV_W:0]  mag_res;
    logic [DERIV_W-1:0] quo_next;
    logic              sat_next;

    always_comb
    begin
        rnd      = ({rem_reg[QB], 1'b0} >= {1'b0, XW'(den_reg[QB])});
        quo_rnd  = {1'b0, quo_reg[QB]} + (QB+1)'(rnd);
        limit    = ctl_reg[QB].neg ? ((DERIV_W+1)'(1) << (DERIV_W - 1))
                                   : (((DERIV_W+1)'(1) << (DERIV_W - 1)) - 1'b1);
        clip     = ovf_reg[QB] || ((QB+1)'(limit) < quo_rnd);
        mag_res  = clip ? limit : (DERIV_W+1)'(quo_rnd);
        quo_next = ctl_reg[QB].neg ? DERIV_W'(-mag_res) : DERIV_W'(mag_res);
        sat_next = clip;
        if (ctl_reg[QB].dz)
        begin
            quo_next = '0;
            sat_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_out <= '0;
        end
        else
        begin
            ctl_out <= ctl_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        quo_out <= quo_next;
        sat_out <= sat_next;
    end

endmodule

### hdl/track_slope_jacobian_unit.sv
// ----------------------------------------------------------------------------
// track_slope_jacobian_unit: slope Jacobian between plane and sector frames
// From start to done a beat passes four arithmetic stages, then
// 35 stages of a divider lane that resolves one quotient bit per stage.
// Throughput is one beat per cycle; busy stays low and done cannot stall.
// Reset clears every valid bit; no beat is in flight after reset.
// ----------------------------------------------------------------------------
module track_slope_jacobian_unit #(
    parameter int FRAC_BITS = 14
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  tsj_pkg::tsj_req_t req,
    output logic              done,
    output tsj_pkg::tsj_res_t res
);
    import tsj_pkg::*;

    localparam int DET_W  = 2 * COMP_W + 1;
    localparam int PD_W   = SLOPE_W + COMP_W;
    localparam int DW     = ((PD_W > COMP_W + FRAC_BITS) ? PD_W : COMP_W + FRAC_BITS) + 2;
    localparam int NW     = ((SLOPE_W + DET_W > DET_W + FRAC_BITS) ?
                             SLOPE_W + DET_W : DET_W + FRAC_BITS) + 1;
    localparam int HALF_L = (DW + 1) / 2;
    localparam int HALF_H = DW - HALF_L;
    localparam int DEN_W  = 2 * DW;

    assign busy = 1'b0;

    // Stage 1: select operands by direction and form the 2x2 determinants.
    logic signed [COMP_W-1:0]  c1 [4], c2 [4], c3 [4], c4 [4], m1 [4], m2 [4], m3 [4];
    logic signed [SLOPE_W-1:0] s_next [4];
    logic signed [COMP_W-1:0]  pa, pb;
    logic signed [DET_W-1:0]   det_c_next [4], det_e_next [4];
    logic signed [PD_W-1:0]    pa_next, pb_next;

    always_comb
    begin
        if (req.req_type == REQ_LAYER_TO_SECTOR)
        begin
            c1 = '{req.axis_u_x, req.axis_u_z, req.axis_u_y, req.axis_u_z};
            c2 = '{req.axis_v_z, req.axis_v_x, req.axis_v_z, req.axis_v_y};
            c3 = '{req.axis_u_z, req.axis_u_x, req.axis_u_z, req.axis_u_y};
            c4 = '{req.axis_v_x, req.axis_v_z, req.axis_v_y, req.axis_v_z};
            m1 = '{req.axis_u_x, req.axis_v_x, req.axis_u_y, req.axis_v_y};
            m2 = '{req.axis_u_z, req.axis_v_z, req.axis_u_z, req.axis_v_z};
            m3 = '{req.normal_x, req.normal_x, req.normal_y, req.normal_y};
            pa = req.axis_u_z;
            pb = req.axis_v_z;
        end
        else
        begin
            c1 = '{req.axis_u_x, req.axis_u_y, req.axis_v_x, req.axis_v_y};
            c2 = '{req.normal_y, req.normal_x, req.normal_y, req.normal_x};
            c3 = '{req.axis_u_y, req.axis_u_x, req.axis_v_y, req.axis_v_x};
            c4 = '{req.normal_x, req.normal_y, req.normal_x, req.normal_y};
            m1 = '{req.axis_u_x, req.axis_u_y, req.axis_v_x, req.axis_v_y};
            m2 = '{req.axis_u_z, req.axis_u_z, req.axis_v_z, req.axis_v_z};
            m3 = '{req.normal_x, req.normal_y, req.normal_x, req.normal_y};
            pa = req.normal_x;
            pb = req.normal_y;
        end
        s_next = '{req.slope_b, req.slope_a, req.slope_b, req.slope_a};
        for (int k = 0; k < 4; k++)
        begin
            det_c_next[k] = DET_W'(c1[k] * c2[k]) - DET_W'(c3[k] * c4[k]);
            det_e_next[k] = DET_W'(m1[k] * req.normal_z) - DET_W'(m2[k] * m3[k]);
        end
        pa_next = PD_W'(req.slope_a * pa);
        pb_next = PD_W'(req.slope_b * pb);
    end

    logic                      v1_reg;
    logic signed [DET_W-1:0]   det_c_reg [4], det_e_reg [4];
    logic signed [SLOPE_W-1:0] s_reg [4];
    logic signed [PD_W-1:0]    pa_reg, pb_reg;
    logic signed [COMP_W-1:0]  wz_reg;

    // Stage 2: numerators and the denominator d.
    logic signed [NW-1:0] num_next [4];
    logic signed [DW-1:0] d_next;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            num_next[k] = NW'(s_reg[k] * det_c_reg[k]) + (NW'(det_e_reg[k]) <<< FRAC_BITS);
        end
        d_next = DW'(pa_reg) + DW'(pb_reg) + (DW'(wz_reg) <<< FRAC_BITS);
    end

    logic                 v2_reg;
    logic signed [NW-1:0] num_reg [4];
    logic signed [DW-1:0] d_reg;

    // Stage 3: magnitudes, signs, the zero flag of d and partial products of d squared.
    logic [NW-1:0]         mag_next [4];
    logic [3:0]            neg_next;
    logic [DW-1:0]         dmag;
    logic [2*HALF_L-1:0]   dll_next;
    logic [HALF_L+HALF_H-1:0] dhl_next;
    logic [2*HALF_H-1:0]   dhh_next;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            neg_next[k] = num_reg[k][NW-1];
            mag_next[k] = neg_next[k] ? NW'(-num_reg[k]) : NW'(num_reg[k]);
        end
        dmag     = d_reg[DW-1] ? DW'(-d_reg) : DW'(d_reg);
        dll_next = dmag[HALF_L-1:0] * dmag[HALF_L-1:0];
        dhl_next = dmag[DW-1:HALF_L] * dmag[HALF_L-1:0];
        dhh_next = dmag[DW-1:HALF_L] * dmag[DW-1:HALF_L];
    end

    logic                     v3_reg;
    logic [NW-1:0]            mag3_reg [4];
    logic [3:0]               neg3_reg;
    logic                     dz3_reg;
    logic [2*HALF_L-1:0]      dll_reg;
    logic [HALF_L+HALF_H-1:0] dhl_reg;
    logic [2*HALF_H-1:0]      dhh_reg;

    // Stage 4: assemble d squared.
    logic [DEN_W-1:0] den_next;

    assign den_next = DEN_W'(dll_reg) + (DEN_W'(dhl_reg) << (HALF_L + 1))
                    + (DEN_W'(dhh_reg) << (2 * HALF_L));

    logic             v4_reg;
    logic [NW-1:0]    mag4_reg [4];
    logic [3:0]       neg4_reg;
    logic             dz4_reg;
    logic [DEN_W-1:0] den_reg;

    // Valid bits of the front stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start && !busy;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Payload of the front stages.
    always_ff @(posedge clk)
    begin
        det_c_reg <= det_c_next;
        det_e_reg <= det_e_next;
        s_reg     <= s_next;
        pa_reg    <= pa_next;
        pb_reg    <= pb_next;
        wz_reg    <= req.normal_z;
        num_reg   <= num_next;
        d_reg     <= d_next;
        mag3_reg  <= mag_next;
        neg3_reg  <= neg_next;
        dz3_reg   <= (d_reg == '0);
        dll_reg   <= dll_next;
        dhl_reg   <= dhl_next;
        dhh_reg   <= dhh_next;
        mag4_reg  <= mag3_reg;
        neg4_reg  <= neg3_reg;
        dz4_reg   <= dz3_reg;
        den_reg   <= den_next;
    end

    // Four divider lanes, one per derivative.
    tsj_ctl_t                   lane_ctl [4];
    logic signed [DERIV_W-1:0]  lane_quo [4];
    logic [3:0]                 lane_sat;

    for (genvar k = 0; k < 4; k++)
    begin : g_lane
        tsj_ctl_t ctl_in;

        assign ctl_in = '{valid: v4_reg, neg: neg4_reg[k], dz: dz4_reg};

        tsj_div_lane #(
            .MAG_W (NW),
            .DEN_W (DEN_W),
            .FRAC  (FRAC_BITS)
        ) u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl_in  (ctl_in),
            .mag_in  (mag4_reg[k]),
            .den_in  (den_reg),
            .ctl_out (lane_ctl[k]),
            .quo_out (lane_quo[k]),
            .sat_out (lane_sat[k])
        );
    end

    // Result beat.
    assign done           = lane_ctl[0].valid;
    assign res.deriv_aa   = lane_quo[0];
    assign res.deriv_ab   = lane_quo[1];
    assign res.deriv_ba   = lane_quo[2];
    assign res.deriv_bb   = lane_quo[3];
    assign res.denom_zero = lane_ctl[0].dz;
    assign res.saturated  = |lane_sat;

endmodule
